[rtl/hsvca_pkg.sv]
// Package for the HSV pixel color adjust block: operation codes, register
// indexes, the divider tag type and the fixed reciprocal constants.
// Used by hsvca_div, hsv_pixel_color_adjust and the testbench.
package hsvca_pkg;

  localparam int HUE_FRAC_BITS_DEF = 8;

  // Operation codes carried in in_tuser
  localparam logic [1:0] OP_SET_HSV = 2'd0;
  localparam logic [1:0] OP_SET_HUE = 2'd1;
  localparam logic [1:0] OP_SET_SAT = 2'd2;
  localparam logic [1:0] OP_SET_VAL = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HUE_MIN = 3'd0;
  localparam logic [2:0] REG_HUE_MAX = 3'd1;
  localparam logic [2:0] REG_SAT_MIN = 3'd2;
  localparam logic [2:0] REG_SAT_MAX = 3'd3;
  localparam logic [2:0] REG_VAL_MIN = 3'd4;
  localparam logic [2:0] REG_VAL_MAX = 3'd5;

  // Hue base in degrees chosen by the forward conversion
  localparam logic [1:0] BASE_0   = 2'd0;
  localparam logic [1:0] BASE_120 = 2'd1;
  localparam logic [1:0] BASE_240 = 2'd2;
  localparam logic [1:0] BASE_360 = 2'd3;

  localparam logic [8:0] HUE_CAP = 9'd359;

  // floor(y / 15300) = (y * RECIP_SECT) >> 37 for y < 2^22
  localparam int          SECT_Y_W   = 22;
  localparam int          SECT_SHIFT = 37;
  localparam logic [23:0] RECIP_SECT = 24'(((64'd1 << 37) + 64'd15299) / 64'd15300);
  // floor(y / 255) = (y * RECIP_255) >> 25 for y < 2^16
  localparam int          R255_SHIFT = 25;
  localparam logic [17:0] RECIP_255  = 18'(((64'd1 << 25) + 64'd254) / 64'd255);

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] idx;
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] vmax;
    logic [1:0] base;
    logic       neg;
    logic       dz;
  } hsvca_tag_t;

endpackage

[rtl/hsvca_div.sv]
// Pipelined two-lane restoring divider, one quotient bit per stage.
// Depends on hsvca_pkg for the tag type that travels beside the operands.
module hsvca_div #(
  parameter int QW = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [QW+7:0]         in_num0,
  input  logic [7:0]            in_den0,
  input  logic [QW+7:0]         in_num1,
  input  logic [7:0]            in_den1,
  input  hsvca_pkg::hsvca_tag_t in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [QW-1:0]         out_quo0,
  output logic [QW-1:0]         out_quo1,
  output hsvca_pkg::hsvca_tag_t out_tag
);

  localparam int W = QW + 8;

  // acc holds {partial remainder, remaining dividend bits / quotient bits}
  function automatic logic [W-1:0] div_step(input logic [W-1:0] acc, input logic [7:0] den);
    logic [8:0] t;
    logic [8:0] d;
    t = acc[W-1:QW-1];
    d = {1'b0, den};
    if (t >= d) begin
      div_step = {8'(t - d), acc[QW-2:0], 1'b1};
    end else begin
      div_step = {t[7:0], acc[QW-2:0], 1'b0};
    end
  endfunction

  logic [QW-1:0]         v_r;
  logic [QW:0]           ld;
  logic [W-1:0]          acc0_r [QW];
  logic [W-1:0]          acc1_r [QW];
  logic [7:0]            den0_r [QW];
  logic [7:0]            den1_r [QW];
  hsvca_pkg::hsvca_tag_t tag_r  [QW];

  always_comb begin
    ld[QW] = out_ready;
    for (int j = QW - 1; j >= 0; j--) begin
      ld[j] = !v_r[j] || ld[j+1];
    end
  end

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_stage
      if (j == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[j] <= 1'b0;
          end else if (ld[j]) begin
            v_r[j] <= in_valid;
          end
        end
        always_ff @(posedge clk) begin
          if (ld[j]) begin
            acc0_r[j] <= div_step(in_num0, in_den0);
            acc1_r[j] <= div_step(in_num1, in_den1);
            den0_r[j] <= in_den0;
            den1_r[j] <= in_den1;
            tag_r[j]  <= in_tag;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[j] <= 1'b0;
          end else if (ld[j]) begin
            v_r[j] <= v_r[j-1];
          end
        end
        always_ff @(posedge clk) begin
          if (ld[j]) begin
            acc0_r[j] <= div_step(acc0_r[j-1], den0_r[j-1]);
            acc1_r[j] <= div_step(acc1_r[j-1], den1_r[j-1]);
            den0_r[j] <= den0_r[j-1];
            den1_r[j] <= den1_r[j-1];
            tag_r[j]  <= tag_r[j-1];
          end
        end
      end
    end
  endgenerate

  assign in_ready  = ld[0];
  assign out_valid = v_r[QW-1];
  assign out_quo0  = acc0_r[QW-1][QW-1:0];
  assign out_quo1  = acc1_r[QW-1][QW-1:0];
  assign out_tag   = tag_r[QW-1];

endmodule

[rtl/hsv_pixel_color_adjust.sv]
// HSV pixel color adjust: RGB to HSV, replace / clamp, HSV back to 8-bit RGB.
// The pipelined divider adds HUE_FRAC_BITS + 6 stages between stages 2 and 3.
// Throughput: one pixel per clock unless the output stalls; each stage holds
// one beat and advances when the next is free, so bubbles close up in a stall.
// Reset (synchronous, rst_n low): empty all stages and load the clamp defaults.
module hsv_pixel_color_adjust #(
  parameter int HUE_FRAC_BITS = hsvca_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] pixel_index, [17:10] cur_red, [25:18] cur_green, [33:26] cur_blue,
  // [42:34] hue_in, [50:43] sat_in, [58:51] val_in, [63:59] zero
  input  logic [63:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] pixel_index_out, [17:10] new_red, [25:18] new_green,
  // [33:26] new_blue, [39:34] zero
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int F  = HUE_FRAC_BITS;
  localparam int HW = 9 + F;   // hue in degrees with F fraction bits
  localparam int QW = 6 + F;   // hue quotient, up to one sector span
  localparam int UW = 6 + F;   // sector span and offset in a sector
  localparam int PW = 14 + F;  // offset * saturation, and 255 * span
  localparam int NW = QW + 8;  // divider dividend
  localparam int YW = hsvca_pkg::SECT_Y_W;

  localparam logic [UW-1:0] SPAN  = UW'(60 * (1 << F));
  localparam logic [PW-1:0] DSPAN = PW'(255 * 60 * (1 << F));
  localparam logic [HW-1:0] H060  = HW'(60 * (1 << F));
  localparam logic [HW-1:0] H120  = HW'(120 * (1 << F));
  localparam logic [HW-1:0] H180  = HW'(180 * (1 << F));
  localparam logic [HW-1:0] H240  = HW'(240 * (1 << F));
  localparam logic [HW-1:0] H300  = HW'(300 * (1 << F));
  localparam logic [HW-1:0] H360  = HW'(360 * (1 << F));

  localparam logic [1:0] MAX_RED   = 2'd0;
  localparam logic [1:0] MAX_GREEN = 2'd1;
  localparam logic [1:0] MAX_BLUE  = 2'd2;

  localparam logic [2:0] SECT0 = 3'd0;
  localparam logic [2:0] SECT1 = 3'd1;
  localparam logic [2:0] SECT2 = 3'd2;
  localparam logic [2:0] SECT3 = 3'd3;
  localparam logic [2:0] SECT4 = 3'd4;
  localparam logic [2:0] SECT5 = 3'd5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [8:0] hue_min_r, hue_max_r;
  logic [7:0] sat_min_r, sat_max_r, val_min_r, val_max_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_min_r <= 9'd0;
      hue_max_r <= 9'd359;
      sat_min_r <= 8'd0;
      sat_max_r <= 8'd255;
      val_min_r <= 8'd0;
      val_max_r <= 8'd255;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        hsvca_pkg::REG_HUE_MIN: hue_min_r <= cfg_pwdata[8:0];
        hsvca_pkg::REG_HUE_MAX: hue_max_r <= cfg_pwdata[8:0];
        hsvca_pkg::REG_SAT_MIN: sat_min_r <= cfg_pwdata[7:0];
        hsvca_pkg::REG_SAT_MAX: sat_max_r <= cfg_pwdata[7:0];
        hsvca_pkg::REG_VAL_MIN: val_min_r <= cfg_pwdata[7:0];
        hsvca_pkg::REG_VAL_MAX: val_max_r <= cfg_pwdata[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      hsvca_pkg::REG_HUE_MIN: cfg_prdata = {23'd0, hue_min_r};
      hsvca_pkg::REG_HUE_MAX: cfg_prdata = {23'd0, hue_max_r};
      hsvca_pkg::REG_SAT_MIN: cfg_prdata = {24'd0, sat_min_r};
      hsvca_pkg::REG_SAT_MAX: cfg_prdata = {24'd0, sat_max_r};
      hsvca_pkg::REG_VAL_MIN: cfg_prdata = {24'd0, val_min_r};
      hsvca_pkg::REG_VAL_MAX: cfg_prdata = {24'd0, val_max_r};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage loads when empty or when the next one loads
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, vo_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ldo;
  logic div_in_ready, div_out_valid;

  assign ldo = !vo_r || out_tready;
  assign ld8 = !v8_r || ldo;
  assign ld7 = !v7_r || ld8;
  assign ld6 = !v6_r || ld7;
  assign ld5 = !v5_r || ld6;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || div_in_ready;
  assign ld1 = !v1_r || ld2;

  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_tvalid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= div_out_valid;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
      if (ld6) v6_r <= v5_r;
      if (ld7) v7_r <= v6_r;
      if (ld8) v8_r <= v7_r;
      if (ldo) vo_r <= v8_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the beat, find max / min and which channel is max
  // ---------------------------------------------------------------------------
  logic [7:0] in_red, in_green, in_blue;
  logic [7:0] mx_nxt, mn_nxt;
  logic [1:0] sel_nxt;

  logic [1:0] op1_r;
  logic [9:0] idx1_r;
  logic [7:0] red1_r, green1_r, blue1_r;
  logic [8:0] hue1_r;
  logic [7:0] sat1_r, val1_r, mx1_r, mn1_r;
  logic [1:0] sel1_r;

  assign in_red   = in_tdata[17:10];
  assign in_green = in_tdata[25:18];
  assign in_blue  = in_tdata[33:26];

  always_comb begin
    // ties prefer red, then green
    if (in_red >= in_green && in_red >= in_blue) begin
      sel_nxt = MAX_RED;
      mx_nxt  = in_red;
    end else if (in_green >= in_blue) begin
      sel_nxt = MAX_GREEN;
      mx_nxt  = in_green;
    end else begin
      sel_nxt = MAX_BLUE;
      mx_nxt  = in_blue;
    end
    mn_nxt = in_red;
    if (in_green < mn_nxt) mn_nxt = in_green;
    if (in_blue < mn_nxt)  mn_nxt = in_blue;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      op1_r    <= in_tuser;
      idx1_r   <= in_tdata[9:0];
      red1_r   <= in_red;
      green1_r <= in_green;
      blue1_r  <= in_blue;
      hue1_r   <= in_tdata[42:34];
      sat1_r   <= in_tdata[50:43];
      val1_r   <= in_tdata[58:51];
      mx1_r    <= mx_nxt;
      mn1_r    <= mn_nxt;
      sel1_r   <= sel_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: build the two dividends: 60 * |diff| * 2^F / delta and
  // 255 * delta / max
  // ---------------------------------------------------------------------------
  logic [7:0]  delta, opa, opb, diff;
  logic        neg;
  logic [1:0]  base_nxt;
  hsvca_pkg::hsvca_tag_t tag_nxt;

  logic [NW-1:0]         num0_2_r, num1_2_r;
  logic [7:0]            den0_2_r, den1_2_r;
  hsvca_pkg::hsvca_tag_t tag2_r;

  always_comb begin
    delta = mx1_r - mn1_r;
    case (sel1_r)
      MAX_RED: begin
        opa = green1_r;
        opb = blue1_r;
      end
      MAX_GREEN: begin
        opa = blue1_r;
        opb = red1_r;
      end
      default: begin
        opa = red1_r;
        opb = green1_r;
      end
    endcase
    neg  = opa < opb;
    diff = neg ? opb - opa : opa - opb;
    case (sel1_r)
      MAX_RED:   base_nxt = neg ? hsvca_pkg::BASE_360 : hsvca_pkg::BASE_0;
      MAX_GREEN: base_nxt = hsvca_pkg::BASE_120;
      default:   base_nxt = hsvca_pkg::BASE_240;
    endcase
    tag_nxt.op   = op1_r;
    tag_nxt.idx  = idx1_r;
    tag_nxt.hue  = hue1_r;
    tag_nxt.sat  = sat1_r;
    tag_nxt.val  = val1_r;
    tag_nxt.vmax = mx1_r;
    tag_nxt.base = base_nxt;
    tag_nxt.neg  = neg;
    tag_nxt.dz   = (delta == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      num0_2_r <= NW'(14'(diff) * 14'd60) << F;
      num1_2_r <= NW'(16'(delta) * 16'd255);
      // a zero divisor only shows up with a zero dividend; divide by one
      den0_2_r <= (delta == 8'd0) ? 8'd1 : delta;
      den1_2_r <= (mx1_r == 8'd0) ? 8'd1 : mx1_r;
      tag2_r   <= tag_nxt;
    end
  end

  logic [QW-1:0]         quo_hue, quo_sat;
  hsvca_pkg::hsvca_tag_t tag_div;

  hsvca_div #(
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (div_in_ready),
    .in_num0   (num0_2_r),
    .in_den0   (den0_2_r),
    .in_num1   (num1_2_r),
    .in_den1   (den1_2_r),
    .in_tag    (tag2_r),
    .out_valid (div_out_valid),
    .out_ready (ld3),
    .out_quo0  (quo_hue),
    .out_quo1  (quo_sat),
    .out_tag   (tag_div)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: finish the hue, then replace components per operation
  // ---------------------------------------------------------------------------
  logic [HW-1:0] hbase, hconv, hop;
  logic [HW-1:0] h_nxt;
  logic [7:0]    s_nxt, vv_nxt;

  logic [HW-1:0] h3_r;
  logic [7:0]    s3_r, v3v_r;
  logic [9:0]    idx3_r;

  always_comb begin
    case (tag_div.base)
      hsvca_pkg::BASE_0:   hbase = '0;
      hsvca_pkg::BASE_120: hbase = H120;
      hsvca_pkg::BASE_240: hbase = H240;
      default:             hbase = H360;
    endcase
    if (tag_div.dz) begin
      hconv = '0;
    end else if (tag_div.neg) begin
      hconv = hbase - HW'(quo_hue);
    end else begin
      hconv = hbase + HW'(quo_hue);
    end
    hop    = HW'(tag_div.hue) << F;
    h_nxt  = hconv;
    s_nxt  = quo_sat[7:0];
    vv_nxt = tag_div.vmax;
    case (tag_div.op)
      hsvca_pkg::OP_SET_HSV: begin
        h_nxt  = hop;
        s_nxt  = tag_div.sat;
        vv_nxt = tag_div.val;
      end
      hsvca_pkg::OP_SET_HUE: h_nxt  = hop;
      hsvca_pkg::OP_SET_SAT: s_nxt  = tag_div.sat;
      default:               vv_nxt = tag_div.val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      h3_r   <= h_nxt;
      s3_r   <= s_nxt;
      v3v_r  <= vv_nxt;
      idx3_r <= tag_div.idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: clamp; hue limits are capped to 359 degrees first
  // ---------------------------------------------------------------------------
  logic [8:0]    hmin_cap, hmax_cap;
  logic [HW-1:0] hlo, hhi;

  logic [HW-1:0] h4_r;
  logic [7:0]    s4_r, v4v_r;
  logic [9:0]    idx4_r;

  assign hmin_cap = (hue_min_r > hsvca_pkg::HUE_CAP) ? hsvca_pkg::HUE_CAP : hue_min_r;
  assign hmax_cap = (hue_max_r > hsvca_pkg::HUE_CAP) ? hsvca_pkg::HUE_CAP : hue_max_r;
  assign hlo      = HW'(hmin_cap) << F;
  assign hhi      = HW'(hmax_cap) << F;

  always_ff @(posedge clk) begin
    if (ld4) begin
      if (h3_r > hhi)      h4_r <= hhi;
      else if (h3_r < hlo) h4_r <= hlo;
      else                 h4_r <= h3_r;
      if (s3_r > sat_max_r)      s4_r <= sat_max_r;
      else if (s3_r < sat_min_r) s4_r <= sat_min_r;
      else                       s4_r <= s3_r;
      if (v3v_r > val_max_r)      v4v_r <= val_max_r;
      else if (v3v_r < val_min_r) v4v_r <= val_min_r;
      else                        v4v_r <= v3v_r;
      idx4_r <= idx3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sector and offset inside the sector
  // ---------------------------------------------------------------------------
  logic [2:0]    k_nxt;
  logic [HW-1:0] kbase;

  logic [2:0]    k5_r;
  logic [UW-1:0] e5_r;
  logic [7:0]    s5_r, v5v_r;
  logic [9:0]    idx5_r;

  always_comb begin
    if (h4_r >= H300) begin
      k_nxt = SECT5;
      kbase = H300;
    end else if (h4_r >= H240) begin
      k_nxt = SECT4;
      kbase = H240;
    end else if (h4_r >= H180) begin
      k_nxt = SECT3;
      kbase = H180;
    end else if (h4_r >= H120) begin
      k_nxt = SECT2;
      kbase = H120;
    end else if (h4_r >= H060) begin
      k_nxt = SECT1;
      kbase = H060;
    end else begin
      k_nxt = SECT0;
      kbase = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      k5_r   <= k_nxt;
      e5_r   <= UW'(h4_r - kbase);
      s5_r   <= s4_r;
      v5v_r  <= v4v_r;
      idx5_r <= idx4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: offset times saturation, and V * (255 - S)
  // ---------------------------------------------------------------------------
  logic [PW-1:0] es6_r, ues6_r;
  logic [15:0]   pn6_r;
  logic [7:0]    v6v_r;
  logic [2:0]    k6_r;
  logic [9:0]    idx6_r;

  always_ff @(posedge clk) begin
    if (ld6) begin
      es6_r  <= PW'(e5_r) * PW'(s5_r);
      ues6_r <= PW'(SPAN - e5_r) * PW'(s5_r);
      pn6_r  <= 16'(v5v_r) * 16'(8'd255 - s5_r);
      v6v_r  <= v5v_r;
      k6_r   <= k5_r;
      idx6_r <= idx5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: V * (D - x), drop the 2^F part of the divisor
  // ---------------------------------------------------------------------------
  logic [PW+7:0] xq, xt;
  logic [YW-1:0] yq7_r, yt7_r;
  logic [15:0]   pn7_r;
  logic [7:0]    v7v_r;
  logic [2:0]    k7_r;
  logic [9:0]    idx7_r;

  assign xq = (PW+8)'(v6v_r) * (PW+8)'(DSPAN - es6_r);
  assign xt = (PW+8)'(v6v_r) * (PW+8)'(DSPAN - ues6_r);

  always_ff @(posedge clk) begin
    if (ld7) begin
      yq7_r  <= xq[F +: YW];
      yt7_r  <= xt[F +: YW];
      pn7_r  <= pn6_r;
      v7v_r  <= v6v_r;
      k7_r   <= k6_r;
      idx7_r <= idx6_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: constant divisions by reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [YW+23:0] mq, mt;
  logic [33:0]    mp;
  logic [7:0]     q8_r, t8_r, p8_r, v8v_r;
  logic [2:0]     k8_r;
  logic [9:0]     idx8_r;

  assign mq = (YW+24)'(yq7_r) * (YW+24)'(hsvca_pkg::RECIP_SECT);
  assign mt = (YW+24)'(yt7_r) * (YW+24)'(hsvca_pkg::RECIP_SECT);
  assign mp = 34'(pn7_r) * 34'(hsvca_pkg::RECIP_255);

  always_ff @(posedge clk) begin
    if (ld8) begin
      q8_r   <= mq[hsvca_pkg::SECT_SHIFT +: 8];
      t8_r   <= mt[hsvca_pkg::SECT_SHIFT +: 8];
      p8_r   <= mp[hsvca_pkg::R255_SHIFT +: 8];
      v8v_r  <= v7v_r;
      k8_r   <= k7_r;
      idx8_r <= idx7_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: six-sector select
  // ---------------------------------------------------------------------------
  logic [7:0] r_nxt, g_nxt, b_nxt;
  logic [9:0] idxo_r;
  logic [7:0] ro_r, go_r, bo_r;

  always_comb begin
    case (k8_r)
      SECT0: begin r_nxt = v8v_r; g_nxt = t8_r;  b_nxt = p8_r;  end
      SECT1: begin r_nxt = q8_r;  g_nxt = v8v_r; b_nxt = p8_r;  end
      SECT2: begin r_nxt = p8_r;  g_nxt = v8v_r; b_nxt = t8_r;  end
      SECT3: begin r_nxt = p8_r;  g_nxt = q8_r;  b_nxt = v8v_r; end
      SECT4: begin r_nxt = t8_r;  g_nxt = p8_r;  b_nxt = v8v_r; end
      default: begin r_nxt = v8v_r; g_nxt = p8_r; b_nxt = q8_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ldo) begin
      idxo_r <= idx8_r;
      ro_r   <= r_nxt;
      go_r   <= g_nxt;
      bo_r   <= b_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {6'd0, bo_r, go_r, ro_r, idxo_r};

endmodule

[rtl/hsvca_chk.sv]
// Port-level checker for hsv_pixel_color_adjust, attached by bind.
// Depends on the top level's ports only.
module hsvca_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [4:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // with the result side free, every stage can advance
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input held off while output is ready");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // hue_min reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 5'd0
    |=> cfg_paddr != 5'd0 || cfg_prdata == {23'd0, $past(cfg_pwdata[8:0])})
    else $error("hue_min readback mismatch");

endmodule

bind hsv_pixel_color_adjust hsvca_chk u_hsvca_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

[tb/hsv_pixel_color_adjust_tb.sv]
// Testbench for hsv_pixel_color_adjust: random and directed pixel requests,
// with a predictor of the HSV clamp and RGB rebuild checked beat by beat.
// Depends on hsvca_pkg and the hsv_pixel_color_adjust RTL.
module hsv_pixel_color_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam longint HONE = 64'd1 << FRAC;
  localparam longint SPAN = 60 * HONE;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] idx;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } pix_req_t;

  typedef struct packed {
    logic [9:0] idx;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;
  } pix_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // clamp limits as the predictor sees them
  logic [8:0] lim_hue_lo, lim_hue_hi;
  logic [7:0] lim_sat_lo, lim_sat_hi, lim_val_lo, lim_val_hi;

  pix_req_t pending_reqs[$];
  pix_res_t expected_pixels[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;  // ask the receiver for its long stall
  int burst_left = 0;
  int gap_left = 0;

  hsv_pixel_color_adjust u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clampv(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Predict one output pixel from a request and the current limits.
  function automatic pix_res_t predict_pixel(pix_req_t rq);
    longint r, g, b, mx, mn, dl, h, s, v, k, e, d, p, q, t, hlo, hhi;
    pix_res_t res;
    r = rq.red; g = rq.grn; b = rq.blu;
    h = rq.hue * HONE; s = rq.sat; v = rq.val;
    if (rq.op != hsvca_pkg::OP_SET_HSV) begin
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dl = mx - mn;
      // ties go to red, then green
      if (dl == 0) h = 0;
      else if (mx == r) h = (g >= b) ? (SPAN * (g - b)) / dl
                                     : 360 * HONE - (SPAN * (b - g)) / dl;
      else if (mx == g) h = (b >= r) ? 120 * HONE + (SPAN * (b - r)) / dl
                                     : 120 * HONE - (SPAN * (r - b)) / dl;
      else h = (r >= g) ? 240 * HONE + (SPAN * (r - g)) / dl
                        : 240 * HONE - (SPAN * (g - r)) / dl;
      if (rq.op == hsvca_pkg::OP_SET_HUE) h = rq.hue * HONE;
      else if (rq.op == hsvca_pkg::OP_SET_SAT) begin
        s = rq.sat; v = mx;
      end else begin
        s = mx ? (255 * dl) / mx : 0; v = rq.val;
      end
      if (rq.op == hsvca_pkg::OP_SET_HUE) begin
        s = mx ? (255 * dl) / mx : 0; v = mx;
      end else if (rq.op == hsvca_pkg::OP_SET_SAT) v = mx;
    end
    // cap hue limits at 359 so the back conversion never sees sector 6
    hlo = ((lim_hue_lo > 359) ? 359 : lim_hue_lo) * HONE;
    hhi = ((lim_hue_hi > 359) ? 359 : lim_hue_hi) * HONE;
    h = clampv(h, hlo, hhi);
    s = clampv(s, lim_sat_lo, lim_sat_hi);
    v = clampv(v, lim_val_lo, lim_val_hi);
    k = h / SPAN;
    e = h - k * SPAN;
    d = 255 * SPAN;
    p = (v * (255 - s)) / 255;
    q = (v * (d - e * s)) / d;
    t = (v * (d - (SPAN - e) * s)) / d;
    case (k)
      0: begin r = v; g = t; b = p; end
      1: begin r = q; g = v; b = p; end
      2: begin r = p; g = v; b = t; end
      3: begin r = p; g = q; b = v; end
      4: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    res.idx = rq.idx; res.red = r[7:0]; res.grn = g[7:0]; res.blu = b[7:0];
    return res;
  endfunction

  // Driver: bursts of beats with random gaps; advance on handshake.
  always @(posedge clk) begin
    pix_req_t nx;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(predict_pixel(pending_reqs.pop_front()));
      end
      if (in_tvalid && !(in_tready)) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !(in_tvalid && in_tready &&
                   pending_reqs.size() == 0)) begin
        nx = pending_reqs[0];
        in_tvalid <= 1'b1;
        in_tuser <= nx.op;
        in_tdata <= {5'd0, nx.val, nx.sat, nx.hue, nx.blu, nx.grn, nx.red, nx.idx};
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: runs of ready and stall of their own lengths,
  // plus one long stall counted here once it is asked for.
  int rx_run = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit rx_mode = 1'b1;
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_mode <= ($urandom_range(0, 3) != 0);
        rx_run <= $urandom_range(1, 20);
      end else rx_run <= rx_run - 1;
      out_tready <= rx_mode;
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    pix_res_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = {out_tdata[9:0], out_tdata[17:10], out_tdata[25:18], out_tdata[33:26]};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (got.idx !== want.idx || got.red !== want.red ||
              got.grn !== want.grn || got.blu !== want.blu) begin
            $display({"%0t: pixel mismatch, expected idx %0d rgb %0d %0d %0d,",
                      " actual idx %0d rgb %0d %0d %0d"},
                     $time, want.idx, want.red, want.grn, want.blu,
                     got.idx, got.red, got.grn, got.blu);
            errors <= errors + 1;
          end
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Write one register over APB: setup then access.
  task automatic write_reg(logic [2:0] ridx, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {ridx, 2'b00}; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (ridx)
      hsvca_pkg::REG_HUE_MIN: lim_hue_lo = data[8:0];
      hsvca_pkg::REG_HUE_MAX: lim_hue_hi = data[8:0];
      hsvca_pkg::REG_SAT_MIN: lim_sat_lo = data[7:0];
      hsvca_pkg::REG_SAT_MAX: lim_sat_hi = data[7:0];
      hsvca_pkg::REG_VAL_MIN: lim_val_lo = data[7:0];
      default:                lim_val_hi = data[7:0];
    endcase
  endtask

  // Wait until every queued request has gone and every result has come back.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pix_req_t rand_req(bit gray);
    pix_req_t rq;
    rq.op = 2'($urandom_range(0, 3));
    rq.idx = 10'($urandom_range(0, 1023));
    rq.red = 8'($urandom_range(0, 255));
    rq.grn = gray ? rq.red : 8'($urandom_range(0, 255));
    rq.blu = gray ? rq.red : 8'($urandom_range(0, 255));
    rq.hue = 9'($urandom_range(0, 511));
    rq.sat = 8'($urandom_range(0, 255));
    rq.val = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  function automatic pix_req_t mk(logic [1:0] op, logic [9:0] idx, logic [7:0] r,
      logic [7:0] g, logic [7:0] b, logic [8:0] h, logic [7:0] s, logic [7:0] v);
    mk = {op, idx, r, g, b, h, s, v};
  endfunction

  initial begin
    lim_hue_lo = 0; lim_hue_hi = 359;
    lim_sat_lo = 0; lim_sat_hi = 255;
    lim_val_lo = 0; lim_val_hi = 255;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, every operation, ties, gray, hue above 359
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_HSV, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_HSV, 1023, 255, 255, 255, 359, 255, 255));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_HSV, 5, 0, 0, 0, 511, 255, 255));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_HSV, 6, 0, 0, 0, 60, 255, 200));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_HSV, 7, 0, 0, 0, 299, 128, 255));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_HUE, 8, 255, 0, 0, 180, 0, 0));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_SAT, 9, 10, 200, 30, 0, 7, 0));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_VAL, 10, 30, 40, 250, 0, 0, 99));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_VAL, 11, 200, 10, 90, 0, 0, 255));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_SAT, 12, 200, 200, 10, 0, 255, 0));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_SAT, 13, 10, 200, 200, 0, 100, 0));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_SAT, 14, 77, 77, 77, 0, 200, 0));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_VAL, 15, 0, 0, 0, 0, 0, 128));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_HUE, 16, 255, 255, 0, 400, 0, 0));
    pending_reqs.push_back(mk(hsvca_pkg::OP_SET_SAT, 17, 90, 0, 200, 0, 50, 0));
    drain();
    // limit settings: extremes, inverted pairs, over-range hue
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(hsvca_pkg::REG_HUE_MIN, 0);
                 write_reg(hsvca_pkg::REG_HUE_MAX, 0); end
        1: begin write_reg(hsvca_pkg::REG_HUE_MIN, 511);
                 write_reg(hsvca_pkg::REG_HUE_MAX, 511); end
        2: begin write_reg(hsvca_pkg::REG_HUE_MIN, 300);
                 write_reg(hsvca_pkg::REG_HUE_MAX, 100); end
        3: begin write_reg(hsvca_pkg::REG_SAT_MIN, 255);
                 write_reg(hsvca_pkg::REG_SAT_MAX, 255);
                 write_reg(hsvca_pkg::REG_VAL_MIN, 0);
                 write_reg(hsvca_pkg::REG_VAL_MAX, 0); end
        4: begin write_reg(hsvca_pkg::REG_SAT_MIN, 200);
                 write_reg(hsvca_pkg::REG_SAT_MAX, 50);
                 write_reg(hsvca_pkg::REG_VAL_MIN, 180);
                 write_reg(hsvca_pkg::REG_VAL_MAX, 40); end
        5: begin write_reg(hsvca_pkg::REG_HUE_MIN, $urandom_range(0, 511));
                 write_reg(hsvca_pkg::REG_HUE_MAX, $urandom_range(0, 511));
                 write_reg(hsvca_pkg::REG_SAT_MIN, $urandom_range(0, 100));
                 write_reg(hsvca_pkg::REG_SAT_MAX, $urandom_range(100, 255));
                 write_reg(hsvca_pkg::REG_VAL_MIN, $urandom_range(0, 100));
                 write_reg(hsvca_pkg::REG_VAL_MAX, $urandom_range(100, 255)); end
        default: begin write_reg(hsvca_pkg::REG_HUE_MIN, 0);
                 write_reg(hsvca_pkg::REG_HUE_MAX, 359);
                 write_reg(hsvca_pkg::REG_SAT_MIN, 0);
                 write_reg(hsvca_pkg::REG_SAT_MAX, 255);
                 write_reg(hsvca_pkg::REG_VAL_MIN, 0);
                 write_reg(hsvca_pkg::REG_VAL_MAX, 255); end
      endcase
      for (int i = 0; i < 140; i++)
        pending_reqs.push_back(rand_req($urandom_range(0, 15) == 0));
      // long output stall while input keeps coming: fill the pipeline
      if (ph == 6) hold_req = 1'b1;
      drain();
    end
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[hsv_pixel_color_adjust.f]
rtl/hsvca_pkg.sv
rtl/hsvca_div.sv
rtl/hsv_pixel_color_adjust.sv
rtl/hsvca_chk.sv
tb/hsv_pixel_color_adjust_tb.sv
